/* sv/length_prefixed_bit_deframer_defines.svh */
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_BIT_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_BIT_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LPBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer next-cycle check failed");

`endif

/* sv/lpbd_pkg.sv */
// Shared types and constants for the length-prefixed bit deframer.
`default_nettype none
package lpbd_pkg;

   localparam int unsigned HEADER_CHARS_DEF = 10;
   localparam int unsigned SENDER_W = 22;
   localparam int unsigned LEN_W = 32;

   localparam logic [LEN_W-1:0] LEN_CAP = 32'h8000_0000;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_BAD_LENGTH = 2'd1,
      ERR_NO_TERM    = 2'd2
   } err_type;

   typedef struct packed {
      logic load;    // a header character is complete
      logic clear;   // frame done, rearm the parser
   } parse_ctl_type;

   typedef struct packed {
      logic             good;    // length is acceptable after this character
      logic [LEN_W-1:0] length;  // parsed body length
   } parse_stat_type;

   typedef struct packed {
      logic [1:0] ack_count;
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       frame_end;
      err_type    error_code;
   } result_type;

endpackage
`default_nettype wire

/* sv/lpbd_hdr_parse.sv */
// Header length parser: whitespace, sign, decimal digits, NUL end.
`default_nettype none
module lpbd_hdr_parse (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lpbd_pkg::parse_ctl_type ctl,
   input  wire logic [7:0]              char_in,
   output lpbd_pkg::parse_stat_type     stat
);
   import lpbd_pkg::*;

   typedef enum logic [1:0] {
      STG_SKIP,
      STG_SIGN,
      STG_DIGITS,
      STG_DONE
   } stage_type;

   stage_type        stage_ff, stage_in;
   logic             neg_ff, neg_in;
   logic             bad_ff, bad_in;
   logic [LEN_W-1:0] accum_ff, accum_in;

   logic             is_digit;
   logic             is_space;
   logic             is_sign;
   logic [LEN_W+3:0] scaled;

   assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign is_space = (char_in == CHAR_SPACE) || ((char_in >= CHAR_TAB) && (char_in <= CHAR_CR));
   assign is_sign  = (char_in == CHAR_MINUS) || (char_in == CHAR_PLUS);

   // times ten as two shifts, then add the digit
   assign scaled = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1)
                 + (LEN_W + 4)'(4'(char_in - CHAR_ZERO));

   always_comb begin
      stage_in = stage_ff;
      neg_in   = neg_ff;
      bad_in   = bad_ff;
      accum_in = accum_ff;
      if (ctl.clear) begin
         stage_in = STG_SKIP;
         neg_in   = 1'b0;
         bad_in   = 1'b0;
         accum_in = '0;
      end else if (ctl.load && (stage_ff != STG_DONE)) begin
         if (char_in == CHAR_NUL) begin
            stage_in = STG_DONE;
         end else if ((stage_ff == STG_SKIP) && is_space) begin
            stage_in = STG_SKIP;
         end else if ((stage_ff == STG_SKIP) && is_sign) begin
            neg_in   = (char_in == CHAR_MINUS);
            stage_in = STG_SIGN;
         end else if (is_digit) begin
            // saturate: anything past the cap is already a bad length
            accum_in = (scaled > {4'b0, LEN_CAP}) ? LEN_CAP : scaled[LEN_W-1:0];
            stage_in = STG_DIGITS;
         end else begin
            bad_in = 1'b1;
         end
      end
   end

   assign stat.good   = !bad_in && !(neg_in && (accum_in != '0)) && !accum_in[LEN_W-1];
   assign stat.length = accum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STG_SKIP;
         neg_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         accum_ff <= '0;
      end else begin
         stage_ff <= stage_in;
         neg_ff   <= neg_in;
         bad_ff   <= bad_in;
         accum_ff <= accum_in;
      end
   end

endmodule
`default_nettype wire

/* sv/lpbd_rsp_reg.sv */
// Result register with valid/stall handshake toward the receiver.
`default_nettype none
module lpbd_rsp_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire lpbd_pkg::result_type result,
   input  wire logic                 rsp_stall,
   output logic                      busy,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_ack_count,
   output logic                      rsp_byte_valid,
   output logic [7:0]                rsp_data_byte,
   output logic                      rsp_frame_end,
   output logic [1:0]                rsp_error_code
);
   import lpbd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   // hold while the receiver stalls a waiting beat
   assign busy     = valid_ff && rsp_stall;
   assign valid_in = load || busy;
   assign res_in   = load ? result : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_ack_count  = res_ff.ack_count;
   assign rsp_byte_valid = res_ff.byte_valid;
   assign rsp_data_byte  = res_ff.data_byte;
   assign rsp_frame_end  = res_ff.frame_end;
   assign rsp_error_code = res_ff.error_code;

endmodule
`default_nettype wire

/* sv/length_prefixed_bit_deframer.sv */
// Length-prefixed bit deframer: framing state, header parse and result register.
//
// Usage: one bit per req_ beat (req_bit_value, req_sender_id). The first bit after
// reset or after a finished frame binds the sender; bits pack LSB-first into bytes.
// The first HEADER_CHARS bytes carry an ASCII decimal length ended by NUL; then
// length+1 body bytes follow, the last of which must be NUL.
// Every accepted beat yields exactly one rsp_ beat: ack_count, byte_valid with
// data_byte, frame_end on a clean finish, and error_code on a bad length header
// or a missing terminator. An error halts the block until reset; halted beats
// still produce an all-zero result.
// Latency: the result of a beat is presented the cycle after it is accepted.
// Throughput: one bit per cycle while rsp_stall holds no waiting result; all per-bit
// work fits between the framing registers and the result register.
// Stall: when rsp_stall holds a waiting result, req_stall rises in the same
// cycle and no new bit is taken until that result is delivered.
// Reset (synchronous, active high) clears the halt, the binding and all framing
// state, and empties the result register.
`default_nettype none
`include "length_prefixed_bit_deframer_defines.svh"
module length_prefixed_bit_deframer #(
   parameter int unsigned HEADER_CHARS = lpbd_pkg::HEADER_CHARS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_bit_value,
   input  wire logic [lpbd_pkg::SENDER_W-1:0] req_sender_id,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_ack_count,
   output logic                               rsp_byte_valid,
   output logic [7:0]                         rsp_data_byte,
   output logic                               rsp_frame_end,
   output logic [1:0]                         rsp_error_code
);
   import lpbd_pkg::*;

   localparam int unsigned HidxW = $clog2(HEADER_CHARS + 1);

   logic                accept;
   logic                halted_ff, halted_in;
   logic                in_body_ff, in_body_in;
   logic                bound_valid_ff, bound_valid_in;
   logic [SENDER_W-1:0] bound_sender_ff, bound_sender_in;
   logic [2:0]          bit_index_ff, bit_index_in;
   logic [7:0]          byte_shift_ff, byte_shift_in;
   logic [HidxW-1:0]    header_index_ff, header_index_in;
   logic [LEN_W-1:0]    body_count_ff, body_count_in;

   logic           byte_done;
   logic [7:0]     byte_merge;
   logic           hdr_last;
   parse_ctl_type  pctl;
   parse_stat_type pstat;
   result_type     result;

   assign accept     = req_valid && !req_stall;
   assign byte_done  = (bit_index_ff == 3'd7);
   assign byte_merge = byte_shift_ff | (8'(req_bit_value) << bit_index_ff);
   assign hdr_last   = (header_index_ff == HidxW'(HEADER_CHARS - 1));

   always_comb begin
      halted_in       = halted_ff;
      in_body_in      = in_body_ff;
      bound_valid_in  = bound_valid_ff;
      bound_sender_in = bound_sender_ff;
      bit_index_in    = bit_index_ff;
      byte_shift_in   = byte_shift_ff;
      header_index_in = header_index_ff;
      body_count_in   = body_count_ff;
      pctl            = '0;
      result          = '{ack_count: 2'd0, byte_valid: 1'b0, data_byte: 8'd0,
                          frame_end: 1'b0, error_code: ERR_NONE};
      if (accept && !halted_ff) begin
         if (!in_body_ff) begin
            if (!bound_valid_ff) begin
               bound_valid_in  = 1'b1;
               bound_sender_in = req_sender_id;
            end
            result.ack_count = 2'd1;
            // foreign bits in the header are acked but dropped
            if (!bound_valid_ff || (req_sender_id == bound_sender_ff)) begin
               bit_index_in  = bit_index_ff + 3'd1;
               byte_shift_in = byte_done ? 8'd0 : byte_merge;
               if (byte_done) begin
                  pctl.load       = 1'b1;
                  header_index_in = hdr_last ? '0 : header_index_ff + HidxW'(1);
                  if (hdr_last) begin
                     if (pstat.good) begin
                        in_body_in    = 1'b1;
                        body_count_in = '0;
                     end else begin
                        halted_in         = 1'b1;
                        result.ack_count  = 2'd0;
                        result.error_code = ERR_BAD_LENGTH;
                     end
                  end
               end
            end
         end else if (req_sender_id == bound_sender_ff) begin
            result.ack_count = 2'd1;
            bit_index_in     = bit_index_ff + 3'd1;
            byte_shift_in    = byte_done ? 8'd0 : byte_merge;
            if (byte_done) begin
               result.byte_valid = 1'b1;
               result.data_byte  = byte_merge;
               if (body_count_ff == pstat.length) begin
                  if (byte_merge != CHAR_NUL) begin
                     halted_in         = 1'b1;
                     result.ack_count  = 2'd0;
                     result.error_code = ERR_NO_TERM;
                  end else begin
                     // clean finish: rearm for a new sender
                     result.ack_count = 2'd2;
                     result.frame_end = 1'b1;
                     pctl.clear       = 1'b1;
                     in_body_in       = 1'b0;
                     bound_valid_in   = 1'b0;
                     bound_sender_in  = '0;
                     bit_index_in     = 3'd0;
                     byte_shift_in    = 8'd0;
                     header_index_in  = '0;
                     body_count_in    = '0;
                  end
               end else begin
                  body_count_in = body_count_ff + LEN_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff       <= 1'b0;
         in_body_ff      <= 1'b0;
         bound_valid_ff  <= 1'b0;
         bound_sender_ff <= '0;
         bit_index_ff    <= 3'd0;
         byte_shift_ff   <= 8'd0;
         header_index_ff <= '0;
         body_count_ff   <= '0;
      end else begin
         halted_ff       <= halted_in;
         in_body_ff      <= in_body_in;
         bound_valid_ff  <= bound_valid_in;
         bound_sender_ff <= bound_sender_in;
         bit_index_ff    <= bit_index_in;
         byte_shift_ff   <= byte_shift_in;
         header_index_ff <= header_index_in;
         body_count_ff   <= body_count_in;
      end
   end

   lpbd_hdr_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .ctl     (pctl),
      .char_in (byte_merge),
      .stat    (pstat)
   );

   lpbd_rsp_reg u_rsp (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .result         (result),
      .rsp_stall      (rsp_stall),
      .busy           (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_ack_count  (rsp_ack_count),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_error_code (rsp_error_code)
   );

   `LPBD_ASSERT_NOW(a_frame_end_acks, clock, reset, rsp_valid && rsp_frame_end, (rsp_ack_count == 2'd2) && rsp_byte_valid && (rsp_data_byte == 8'd0))
   `LPBD_ASSERT_NOW(a_error_no_ack, clock, reset, rsp_valid && (rsp_error_code != ERR_NONE), rsp_ack_count == 2'd0)
   `LPBD_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff)
   `LPBD_ASSERT_NEXT(a_halted_silent, clock, reset, accept && halted_ff, rsp_valid && (rsp_ack_count == 2'd0) && !rsp_byte_valid && !rsp_frame_end)

endmodule
`default_nettype wire
